// ===== sv/ost_pkg.sv =====
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types, codes and constants of the ORAM stash table.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int unsigned    LEAF_BITS   = 16;
  localparam logic [3:0]     MAX_EVICT   = 4'd8;
  localparam logic [4:0]     LEVELS_RST  = 5'd17;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_LEVEL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_RUN,
    S_EMIT,
    S_CHECK
  } ctl_state_t;

  typedef struct packed {
    logic [23:0] id;
    logic [15:0] leaf;
    logic [63:0] data;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [23:0] block_id;
    logic [15:0] leaf;
    logic [63:0] payload;
    logic [4:0]  level;
    logic [3:0]  max_count;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic        entry_valid;
    logic [23:0] out_block_id;
    logic [15:0] out_leaf;
    logic [63:0] out_payload;
    logic        present;
    logic        duplicate;
    logic        last;
  } out_rsp_t;

  typedef struct packed {
    logic        active;
    op_t         op;
    logic [23:0] key_id;
    logic [15:0] key_leaf;
    logic [15:0] mask;
    entry_t      carry;
    logic        carry_v;
    logic        placing;
    logic        found;
    logic [1:0]  hits;
  } wave_t;

  function automatic out_rsp_t rsp_of_entry(entry_t e, logic last);
    out_rsp_t r;
    r              = '0;
    r.status       = ST_OK;
    r.entry_valid  = 1'b1;
    r.out_block_id = e.id;
    r.out_leaf     = e.leaf;
    r.out_payload  = e.data;
    r.last         = last;
    return r;
  endfunction

endpackage

// ===== sv/oram_stash_table_core.sv =====
// Timing: an insert, remove or lookup sends one wave through the STASH_DEPTH cells, then emits;
// full-stash inserts and bad-level or zero-count evicts skip the chain and go straight to emit.
// Evict sends one wave per entry taken, plus one empty wave when fewer than max_count match,
// so at most max_count waves (max_count clamped to MAX_EVICT), plus out_ready stalls.
// Flow: one request at a time; in_ready is high only in the idle state.
// Reset (rst_n low, synchronous): stash empty, fill count 0, tree_levels 17, no result.
// ----------------------------------------------------------------------------
// oram_stash_table_core
// Path ORAM stash: a sorted chain of slot cells driven by a request sequencer.
// ----------------------------------------------------------------------------
module oram_stash_table_core import ost_pkg::*; #(
  parameter int unsigned STASH_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_req_t    in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output out_rsp_t   out_rsp,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  wave_t  wave_link [STASH_DEPTH+1];
  entry_t ent_w     [STASH_DEPTH+1];
  logic   vld_w     [STASH_DEPTH+1];

  assign ent_w[STASH_DEPTH] = '0;
  assign vld_w[STASH_DEPTH] = 1'b0;

  ost_ctrl #(.STASH_DEPTH(STASH_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wave_launch (wave_link[0]),
    .wave_exit   (wave_link[STASH_DEPTH])
  );

  for (genvar i = 0; i < STASH_DEPTH; i++) begin : g_cell
    ost_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wave_in   (wave_link[i]),
      .right_ent (ent_w[i+1]),
      .right_vld (vld_w[i+1]),
      .ent       (ent_w[i]),
      .vld       (vld_w[i]),
      .wave_out  (wave_link[i+1])
    );
  end

endmodule

// ===== sv/ost_cell.sv =====
// ----------------------------------------------------------------------------
// ost_cell
// One stash slot. Acts on the request wave as it passes and forwards it.
// ----------------------------------------------------------------------------
module ost_cell import ost_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  wave_t  wave_in,
  input  entry_t right_ent,
  input  logic   right_vld,
  output entry_t ent,
  output logic   vld,
  output wave_t  wave_out
);

  entry_t ent_r, ent_nxt;
  logic   vld_r, vld_nxt;
  wave_t  wave_r, wave_nxt;
  logic   id_hit, leaf_hit;

  assign id_hit   = vld_r && (ent_r.id == wave_in.key_id);
  assign leaf_hit = vld_r && (((ent_r.leaf ^ wave_in.key_leaf) & wave_in.mask) == 16'd0);

  always_comb begin
    ent_nxt  = ent_r;
    vld_nxt  = vld_r;
    wave_nxt = wave_in;
    if (wave_in.active) begin
      unique case (wave_in.op)
        OP_INSERT: begin
          if (wave_in.carry_v &&
              (wave_in.placing || !vld_r || (ent_r.leaf > wave_in.carry.leaf))) begin
            ent_nxt          = wave_in.carry;
            vld_nxt          = 1'b1;
            wave_nxt.carry   = ent_r;
            wave_nxt.carry_v = vld_r;
            wave_nxt.placing = 1'b1;
          end
        end
        OP_REMOVE, OP_EVICT: begin
          if (wave_in.found || ((wave_in.op == OP_REMOVE) ? id_hit : leaf_hit)) begin
            ent_nxt = right_ent;
            vld_nxt = right_vld;
            if (!wave_in.found) begin
              wave_nxt.found = 1'b1;
              wave_nxt.carry = ent_r;
            end
          end
        end
        OP_LOOKUP: begin
          if (id_hit && (wave_in.hits != 2'd2)) begin
            wave_nxt.hits = wave_in.hits + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      vld_r  <= 1'b0;
      wave_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      wave_r <= wave_nxt;
    end
  end

  assign ent      = ent_r;
  assign vld      = vld_r;
  assign wave_out = wave_r;

endmodule

// ===== sv/ost_ctrl.sv =====
// ----------------------------------------------------------------------------
// ost_ctrl
// Request sequencer: launches waves into the cell chain, collects their
// outcome, keeps the fill count and drives the result register.
// ----------------------------------------------------------------------------
module ost_ctrl import ost_pkg::*; #(
  parameter int unsigned STASH_DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp,
  input  logic     cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  output wave_t    wave_launch,
  input  wave_t    wave_exit
);

  localparam int unsigned     FILL_W = $clog2(STASH_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(STASH_DEPTH);

  ctl_state_t        state_r, state_nxt;
  in_req_t           req_r, req_nxt;
  logic [15:0]       mask_r, mask_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [3:0]        taken_r, taken_nxt;
  entry_t            pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  out_rsp_t          res_r, res_nxt;
  logic              final_r, final_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_rsp_r, out_rsp_nxt;
  logic [4:0]        levels_r, levels_nxt;

  logic              out_free, full, bad_level, direct_rsp;
  logic [4:0]        shift;
  logic [3:0]        cnt_clamp;
  out_rsp_t          rsp_none;

  assign out_free   = !out_valid_r || out_ready;
  assign full       = (fill_r == FILL_MAX);
  assign bad_level  = (in_req.level >= levels_r);
  assign shift      = levels_r - in_req.level - 5'd1;
  assign cnt_clamp  = (in_req.max_count > MAX_EVICT) ? MAX_EVICT : in_req.max_count;
  assign direct_rsp = ((in_req.op == OP_INSERT) && full) ||
                      ((in_req.op == OP_EVICT) && (bad_level || (cnt_clamp == 4'd0)));

  always_comb begin
    rsp_none      = '0;
    rsp_none.last = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = direct_rsp ? S_EMIT : S_LAUNCH;
      end
      S_LAUNCH: state_nxt = S_RUN;
      S_RUN: begin
        if (wave_exit.active) begin
          if ((req_r.op == OP_EVICT) && wave_exit.found && !pend_v_r) state_nxt = S_CHECK;
          else state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) state_nxt = final_r ? S_IDLE : S_CHECK;
      end
      S_CHECK: state_nxt = (taken_r == cnt_r) ? S_EMIT : S_LAUNCH;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    taken_nxt     = taken_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    res_nxt       = res_r;
    final_nxt     = final_r;
    fill_nxt      = fill_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r;
    levels_nxt    = levels_r;
    if (cfg_wr_en) levels_nxt = cfg_wr_data;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req;
          mask_nxt   = (shift >= 5'(LEAF_BITS)) ? 16'd0 : (16'hFFFF << shift);
          cnt_nxt    = cnt_clamp;
          taken_nxt  = 4'd0;
          pend_v_nxt = 1'b0;
          final_nxt  = 1'b1;
          res_nxt    = rsp_none;
          if ((in_req.op == OP_INSERT) && full) res_nxt.status = ST_FULL;
          if ((in_req.op == OP_EVICT) && bad_level) res_nxt.status = ST_BAD_LEVEL;
        end
      end
      S_RUN: begin
        if (wave_exit.active) begin
          res_nxt   = rsp_none;
          final_nxt = 1'b1;
          unique case (req_r.op)
            OP_INSERT: fill_nxt = fill_r + FILL_W'(1);
            OP_REMOVE: begin
              if (wave_exit.found) begin
                res_nxt  = rsp_of_entry(wave_exit.carry, 1'b1);
                fill_nxt = fill_r - FILL_W'(1);
              end else begin
                res_nxt.status = ST_NOT_FOUND;
              end
            end
            OP_LOOKUP: begin
              res_nxt.present   = (wave_exit.hits != 2'd0);
              res_nxt.duplicate = wave_exit.hits[1];
            end
            OP_EVICT: begin
              if (wave_exit.found) begin
                fill_nxt   = fill_r - FILL_W'(1);
                pend_nxt   = wave_exit.carry;
                pend_v_nxt = 1'b1;
                taken_nxt  = taken_r + 4'd1;
                if (pend_v_r) begin
                  res_nxt   = rsp_of_entry(pend_r, 1'b0);
                  final_nxt = 1'b0;
                end
              end else if (pend_v_r) begin
                res_nxt = rsp_of_entry(pend_r, 1'b1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = res_r;
        end
      end
      S_CHECK: begin
        if (taken_r == cnt_r) begin
          res_nxt   = rsp_of_entry(pend_r, 1'b1);
          final_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wave_launch = '0;
    if (state_r == S_LAUNCH) begin
      wave_launch.active     = 1'b1;
      wave_launch.op         = req_r.op;
      wave_launch.key_id     = req_r.block_id;
      wave_launch.key_leaf   = req_r.leaf;
      wave_launch.mask       = mask_r;
      wave_launch.carry.id   = req_r.block_id;
      wave_launch.carry.leaf = req_r.leaf;
      wave_launch.carry.data = req_r.payload;
      wave_launch.carry_v    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    mask_r    <= mask_nxt;
    cnt_r     <= cnt_nxt;
    taken_r   <= taken_nxt;
    pend_r    <= pend_nxt;
    res_r     <= res_nxt;
    final_r   <= final_nxt;
    out_rsp_r <= out_rsp_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      levels_r    <= LEVELS_RST;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      levels_r    <= levels_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FILL_MAX)
    else $error("fill count beyond stash depth");
  a_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    wave_exit.active |-> state_r == S_RUN)
    else $error("wave exit outside run state");
  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> taken_r <= cnt_r)
    else $error("evict took more than requested");
  a_launch_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAUNCH) |=> state_r == S_RUN)
    else $error("launch not followed by run");
`endif

endmodule

// ===== sim/oram_stash_table_checker.sv =====
// ----------------------------------------------------------------------------
// oram_stash_table_checker
// Watches both channels of the stash table, predicts every response from a
// behavioral copy of the sorted stash and compares field by field.
// ----------------------------------------------------------------------------
module oram_stash_table_checker import ost_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_req_t    in_req,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_rsp_t   out_rsp,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  output int         fail_count,
  output int         pending
);

  entry_t     stash_q[$];
  logic [4:0] levels;
  out_rsp_t   rsp_q[$];

  function automatic out_rsp_t status_rsp(status_t st);
    out_rsp_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic out_rsp_t entry_rsp(entry_t e);
    out_rsp_t r;
    r              = '0;
    r.status       = ST_OK;
    r.entry_valid  = 1'b1;
    r.out_block_id = e.id;
    r.out_leaf     = e.leaf;
    r.out_payload  = e.data;
    return r;
  endfunction

  function automatic void queue_rsp(out_rsp_t r);
    rsp_q = {rsp_q, r};
  endfunction

  task automatic apply_request(in_req_t q);
    int     pos;
    int     hits;
    int     shift;
    int     taken;
    int     lim;
    entry_t e;
    entry_t kept[$];
    out_rsp_t r;
    case (q.op)
      OP_INSERT: begin
        if (stash_q.size() >= DEPTH) begin
          queue_rsp(status_rsp(ST_FULL));
        end else begin
          pos = stash_q.size();
          for (int i = 0; i < stash_q.size(); i++)
            if (stash_q[i].leaf > q.leaf) begin
              pos = i;
              break;
            end
          e.id = q.block_id;
          e.leaf = q.leaf;
          e.data = q.payload;
          stash_q.insert(pos, e);
          queue_rsp(status_rsp(ST_OK));
        end
      end
      OP_REMOVE: begin
        pos = -1;
        for (int i = 0; i < stash_q.size(); i++)
          if (stash_q[i].id == q.block_id) begin
            pos = i;
            break;
          end
        if (pos < 0) begin
          queue_rsp(status_rsp(ST_NOT_FOUND));
        end else begin
          r = entry_rsp(stash_q[pos]);
          r.last = 1'b1;
          queue_rsp(r);
          stash_q.delete(pos);
        end
      end
      OP_LOOKUP: begin
        hits = 0;
        foreach (stash_q[i]) if (stash_q[i].id == q.block_id) hits++;
        r = status_rsp(ST_OK);
        r.present = hits >= 1;
        r.duplicate = hits >= 2;
        queue_rsp(r);
      end
      default: begin
        if (q.level >= levels) begin
          queue_rsp(status_rsp(ST_BAD_LEVEL));
        end else begin
          shift = levels - q.level - 1;
          lim = (q.max_count > MAX_EVICT) ? MAX_EVICT : q.max_count;
          taken = 0;
          foreach (stash_q[i]) begin
            if ((shift >= LEAF_BITS || (stash_q[i].leaf >> shift) == (q.leaf >> shift))
                && taken < lim) begin
              queue_rsp(entry_rsp(stash_q[i]));
              taken++;
            end else begin
              kept = {kept, stash_q[i]};
            end
          end
          stash_q = kept;
          if (taken == 0) queue_rsp(status_rsp(ST_OK));
          else rsp_q[rsp_q.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_rsp_t x;
    if (!rst_n) begin
      stash_q.delete();
      rsp_q.delete();
      levels <= LEVELS_RST;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) levels <= cfg_wr_data;
      if (in_valid && in_ready) apply_request(in_req);
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected response %h", out_rsp);
        end else begin
          x = rsp_q.pop_front();
          if (x !== out_rsp) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", x, out_rsp);
          end
        end
      end
      pending <= rsp_q.size();
    end
  end

endmodule

// ===== sim/tb_oram_stash_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_oram_stash_table_core
// Drives directed and random stash requests with random gaps and stalls
// through several tree_levels settings; the checker judges every response.
// ----------------------------------------------------------------------------
module tb_oram_stash_table_core;
  import ost_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_req_t    in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_rsp_t   out_rsp;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  bit         hold_off = 1'b0;
  logic [23:0] id_pool[8];
  logic [15:0] recent_leaf = '0;

  oram_stash_table_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req(in_req), .out_valid(out_valid), .out_ready(out_ready),
    .out_rsp(out_rsp), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  oram_stash_table_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req(in_req), .out_valid(out_valid), .out_ready(out_ready),
    .out_rsp(out_rsp), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 12000000) begin
      $display("oram_stash_table_core verification failed");
      $finish;
    end
  end

  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_done) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(in_req_t q, int no_gap);
    int gap;
    gap = (no_gap != 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1300) @(negedge clk);
  endtask

  task automatic set_levels(logic [4:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic in_req_t mk(op_t op, int id, int leaf, int lvl, int cnt);
    in_req_t q;
    q.op = op;
    q.block_id = 24'(id);
    q.leaf = 16'(leaf);
    q.payload = {$urandom, $urandom};
    q.level = 5'(lvl);
    q.max_count = 4'(cnt);
    return q;
  endfunction

  function automatic in_req_t rnd_req(int lvmax);
    in_req_t q;
    int p;
    p = $urandom_range(0, 99);
    q = mk(OP_INSERT, ($urandom_range(0, 9) == 0) ? 24'($urandom) : id_pool[$urandom_range(0, 7)],
           ($urandom_range(0, 2) == 0) ? recent_leaf : 16'($urandom),
           5'($urandom_range(0, lvmax)), 4'($urandom_range(0, 15)));
    if (p < 45) q.op = OP_INSERT;
    else if (p < 65) q.op = OP_REMOVE;
    else if (p < 80) q.op = OP_LOOKUP;
    else q.op = OP_EVICT;
    if ($urandom_range(0, 19) == 0) q.level = 5'($urandom);
    return q;
  endfunction

  initial begin
    int      n;
    logic [4:0] lv[5];
    foreach (id_pool[i]) id_pool[i] = 24'($urandom);
    id_pool[0] = '0;
    id_pool[1] = 24'hFFFFFF;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(mk(OP_EVICT, 0, 0, 0, 4), 0);
    send(mk(OP_REMOVE, 24'hFFFFFF, 0, 0, 1), 0);
    send(mk(OP_INSERT, 24'h0, 16'h0, 0, 1), 0);
    send(mk(OP_INSERT, 24'hFFFFFF, 16'hFFFF, 0, 1), 0);
    send(mk(OP_INSERT, 24'hFFFFFF, 16'h8000, 0, 1), 0);
    send(mk(OP_INSERT, 24'h123456, 16'h8000, 0, 1), 0);
    send(mk(OP_LOOKUP, 24'hFFFFFF, 0, 0, 1), 0);
    send(mk(OP_LOOKUP, 24'h123456, 0, 0, 1), 0);
    send(mk(OP_LOOKUP, 24'h777777, 0, 0, 1), 0);
    send(mk(OP_EVICT, 0, 16'h8000, 5'd17, 1), 0);
    send(mk(OP_EVICT, 0, 16'h8000, 5'd31, 1), 0);
    send(mk(OP_EVICT, 0, 16'h8000, 5'd15, 0), 0);
    send(mk(OP_EVICT, 0, 16'h8001, 5'd15, 4'd15), 0);
    send(mk(OP_REMOVE, 24'hFFFFFF, 0, 0, 1), 0);
    send(mk(OP_EVICT, 0, 0, 5'd0, 4'd8), 0);
    send(mk(OP_REMOVE, 24'h0, 0, 0, 1), 0);

    // fill to the full stash while the receiver holds off
    hold_off = 1'b1;
    for (int i = 0; i < 130; i++)
      send(mk(OP_INSERT, 24'($urandom_range(0, 3)), 16'($urandom), 0, 1), 1);
    drain();
    for (int i = 0; i < 17; i++) send(mk(OP_EVICT, 0, 16'($urandom), 0, 4'd8), 0);

    lv[0] = 5'd1; lv[1] = 5'd4; lv[2] = 5'd16; lv[3] = 5'd0; lv[4] = 5'd17;
    n = 0;
    foreach (lv[k]) begin
      set_levels(lv[k]);
      for (int i = 0; i < 45; i++) begin
        in_req_t q;
        q = rnd_req((lv[k] == 0) ? 2 : lv[k]);
        send(q, ($urandom_range(0, 4) == 0));
        if (q.op == OP_INSERT) recent_leaf = q.leaf;
        n++;
      end
    end
    set_levels(5'd31);
    repeat (20) send(rnd_req(20), 0);

    drain();
    if (fail_count == 0)
      $display("oram_stash_table_core verification clean");
    else
      $display("oram_stash_table_core verification failed");
    $finish;
  end

endmodule
